// File: design/tom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Train occupancy monitor package
// Shared types, codes, reciprocal constants and text helpers.
// ----------------------------------------------------------------------------
package tom_pkg;

  typedef enum logic [3:0] {
    ST_NOT_STARTED = 4'd0,
    ST_WAITING     = 4'd1,
    ST_ENTERED     = 4'd2,
    ST_LEAVING     = 4'd3,
    ST_COMPUTE     = 4'd4,
    ST_SAVE_AXLES  = 4'd5,
    ST_SAVE_SERIAL = 4'd6,
    ST_SAVE_ENTRY  = 4'd7,
    ST_SAVE_EXIT   = 4'd8,
    ST_POST        = 4'd9
  } tom_state_e;

  // Section status codes.
  localparam logic [1:0] SectClear    = 2'd1;
  localparam logic [1:0] SectOccupied = 2'd2;

  localparam logic [31:0] SecsPerDay = 32'd86400;
  localparam logic [15:0] MaxFour    = 16'd9999;
  localparam logic [15:0] MaxThree   = 16'd999;
  localparam logic [15:0] Hundred    = 16'd100;
  localparam logic [15:0] Ten        = 16'd10;

  // Reciprocal multipliers: x / 60 for x < 86400 is (x * 139811) >> 23,
  // x / 60 for x < 1440 is (x * 2185) >> 17, x / 100 for x < 43699 is
  // (x * 5243) >> 19, and x / 10 for x < 128 is (x * 205) >> 11.
  localparam logic [17:0] RecipSec60 = 18'd139811;
  localparam logic [11:0] RecipMin60 = 12'd2185;
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam logic [7:0]  Recip10    = 8'd205;

  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;

  // One duration being converted to HH:MM:SS.
  typedef struct packed {
    logic        neg;
    logic        over;
    logic [16:0] sec;
    logic [10:0] mins;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [3:0]  hh_t;
    logic [3:0]  hh_o;
    logic [3:0]  mm_t;
    logic [3:0]  mm_o;
    logic [3:0]  ss_t;
    logic [3:0]  ss_o;
  } dur_t;

  // One count being converted to four decimal characters.
  typedef struct packed {
    logic       over;
    logic       ge1000;
    logic       ge100;
    logic       ge10;
    logic [6:0] hi;
    logic [6:0] lo;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } cnt_t;

  // One result beat before packing.
  typedef struct packed {
    logic        record_valid;
    logic [31:0] exit_seconds;
    logic [31:0] entry_seconds;
    logic [31:0] serial_text;
    logic [31:0] axle_text;
    logic [63:0] loading_text;
    logic [63:0] occupied_text;
    logic [3:0]  monitor_state;
  } res_t;

  // Splits a value below 100 into tens and ones digits.
  function automatic logic [7:0] split_dec(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = 15'(v) * 15'(Recip10);
    t = p[14:11];
    o = v - 7'(7'(t) * 7'd10);
    return {t, o[3:0]};
  endfunction

  function automatic logic [7:0] asc(input logic [3:0] d);
    return ChZero | {4'b0000, d};
  endfunction

  function automatic logic [63:0] dur_text(input dur_t d);
    logic [7:0] f;
    f = d.neg ? ChQuest : ChStar;
    if (d.neg || d.over) begin
      return {f, f, ChColon, f, f, ChColon, f, f};
    end
    return {asc(d.hh_t), asc(d.hh_o), ChColon, asc(d.mm_t), asc(d.mm_o),
            ChColon, asc(d.ss_t), asc(d.ss_o)};
  endfunction

  function automatic logic [31:0] axle_text(input cnt_t c);
    if (c.over) begin
      return {ChStar, ChStar, ChStar, ChStar};
    end
    return {asc(c.d3), asc(c.d2), asc(c.d1), asc(c.d0)};
  endfunction

  function automatic logic [31:0] serial_text(input cnt_t c);
    if (c.over) begin
      return {ChStar, ChStar, ChStar, ChStar};
    end
    if (c.ge1000) begin
      return {asc(c.d3), asc(c.d2), asc(c.d1), asc(c.d0)};
    end
    return {ChSpace, c.ge100 ? asc(c.d2) : ChSpace,
            c.ge10 ? asc(c.d1) : ChSpace, asc(c.d0)};
  endfunction

endpackage
`default_nettype wire

// File: design/train_occupancy_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Train occupancy monitor
// Follows one train through a loading section, one status tick per beat, and
// posts a text record with durations, axle count and serial number.
// ----------------------------------------------------------------------------
// The result of an accepted tick is registered in the output or the skid register.
// One tick per cycle while skid is free; each sequencing tick runs one conversion step.
// An output register plus a skid register keep the slave side open while one
// result waits. Reset (rst_ni low, asynchronous) empties both output entries,
// clears the enable, the stamps, the counts and the serial number, and puts the
// sequencer in the not-started state.
// ----------------------------------------------------------------------------
module train_occupancy_monitor (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration: monitor_enabled.
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_wdata_i,
  // Tick input. tdata: section_status[1:0], axle count[17:2],
  // now_seconds[49:18], zero fill[55:50].
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [55:0]  s_axis_tdata,
  // Result output. tdata: monitor_state[3:0], occupied_text[67:4],
  // loading_text[131:68], axle_text[163:132], serial_text[195:164],
  // entry_seconds[227:196], exit_seconds[259:228], zero fill[263:260].
  // tuser: record_valid.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [263:0]      m_axis_tdata,
  output logic              m_axis_tuser
);

  // Unpacked tick fields.
  logic [1:0]  section_status;
  logic [15:0] axles_in;
  logic [31:0] now_seconds;

  assign section_status = s_axis_tdata[1:0];
  assign axles_in       = s_axis_tdata[17:2];
  assign now_seconds    = s_axis_tdata[49:18];

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Sequencer and train bookkeeping.
  logic                  enabled_q;
  tom_pkg::tom_state_e   state_q, state_d;
  logic [15:0]           peak_q, peak_d;
  logic [15:0]           rev_q, rev_d;
  logic [31:0]           entry_q, entry_d;
  logic [31:0]           load_q, load_d;
  logic [31:0]           exit_q, exit_d;
  logic [15:0]           serial_q, serial_d;
  tom_pkg::res_t         res_d;

  // Text conversion lanes: durations 0 occupied, 1 loading; counts 0 axles,
  // 1 serial. One conversion step runs on each tick of the compute and save
  // states, so the digits are ready when the post tick arrives.
  tom_pkg::dur_t dur_q [2];
  tom_pkg::dur_t dur_d [2];
  tom_pkg::cnt_t cnt_q [2];
  tom_pkg::cnt_t cnt_d [2];

  logic [31:0] dur_to   [2];
  logic [32:0] diff     [2];
  logic [34:0] min_prod [2];
  logic [22:0] hh_prod  [2];
  logic [16:0] ss_full  [2];
  logic [10:0] mm_full  [2];
  logic [15:0] cnt_src  [2];
  logic [28:0] hi_prod  [2];
  logic [15:0] lo_full  [2];

  assign dur_to[0]  = exit_q;
  assign dur_to[1]  = load_q;
  assign cnt_src[0] = peak_q;
  assign cnt_src[1] = serial_q;

  // Arithmetic for every step, each lane on its own.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      diff[i]     = {1'b0, dur_to[i]} - {1'b0, entry_q};
      min_prod[i] = 35'(dur_q[i].sec) * 35'(tom_pkg::RecipSec60);
      hh_prod[i]  = 23'(dur_q[i].mins) * 23'(tom_pkg::RecipMin60);
      ss_full[i]  = dur_q[i].sec - 17'(17'(dur_q[i].mins) * 17'd60);
      mm_full[i]  = dur_q[i].mins - 11'(11'(dur_q[i].hh) * 11'd60);
      hi_prod[i]  = 29'(cnt_src[i]) * 29'(tom_pkg::Recip100);
      lo_full[i]  = cnt_src[i] - 16'(16'(cnt_q[i].hi) * tom_pkg::Hundred);
    end
  end

  // Conversion steps, advanced by accepted ticks.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dur_d[i] = dur_q[i];
      cnt_d[i] = cnt_q[i];
      if (in_fire) begin
        case (state_q)
          tom_pkg::ST_COMPUTE: begin
            dur_d[i].neg    = diff[i][32];
            dur_d[i].over   = !diff[i][32] && (diff[i][31:0] >= tom_pkg::SecsPerDay);
            dur_d[i].sec    = diff[i][16:0];
            cnt_d[i].over   = cnt_src[i] > tom_pkg::MaxFour;
            cnt_d[i].ge1000 = cnt_src[i] > tom_pkg::MaxThree;
            cnt_d[i].ge100  = cnt_src[i] >= tom_pkg::Hundred;
            cnt_d[i].ge10   = cnt_src[i] >= tom_pkg::Ten;
          end
          tom_pkg::ST_SAVE_AXLES: begin
            dur_d[i].mins = min_prod[i][33:23];
            cnt_d[i].hi   = hi_prod[i][25:19];
          end
          tom_pkg::ST_SAVE_SERIAL: begin
            dur_d[i].ss = ss_full[i][5:0];
            dur_d[i].hh = hh_prod[i][21:17];
            cnt_d[i].lo = lo_full[i][6:0];
          end
          tom_pkg::ST_SAVE_ENTRY: begin
            dur_d[i].mm = mm_full[i][5:0];
            {dur_d[i].hh_t, dur_d[i].hh_o} = tom_pkg::split_dec({2'b00, dur_q[i].hh});
            {dur_d[i].ss_t, dur_d[i].ss_o} = tom_pkg::split_dec({1'b0, dur_q[i].ss});
            {cnt_d[i].d3, cnt_d[i].d2}     = tom_pkg::split_dec(cnt_q[i].hi);
          end
          tom_pkg::ST_SAVE_EXIT: begin
            {dur_d[i].mm_t, dur_d[i].mm_o} = tom_pkg::split_dec({1'b0, dur_q[i].mm});
            {cnt_d[i].d1, cnt_d[i].d0}     = tom_pkg::split_dec(cnt_q[i].lo);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Next state, bookkeeping and the result of the accepted tick.
  always_comb begin
    state_d  = state_q;
    peak_d   = peak_q;
    rev_d    = rev_q;
    entry_d  = entry_q;
    load_d   = load_q;
    exit_d   = exit_q;
    serial_d = serial_q;
    res_d    = '0;
    if (in_fire) begin
      case (state_q)
        tom_pkg::ST_NOT_STARTED: begin
          if (enabled_q) begin
            state_d = tom_pkg::ST_WAITING;
          end
        end
        tom_pkg::ST_WAITING: begin
          if (section_status == tom_pkg::SectOccupied) begin
            state_d = tom_pkg::ST_ENTERED;
            peak_d  = axles_in;
            entry_d = now_seconds;
          end
        end
        tom_pkg::ST_ENTERED: begin
          if (axles_in > peak_q) begin
            peak_d = axles_in;
          end else if (axles_in < peak_q) begin
            // The count falls back: the train reverses for loading.
            rev_d   = axles_in;
            load_d  = now_seconds;
            state_d = tom_pkg::ST_LEAVING;
          end
        end
        tom_pkg::ST_LEAVING: begin
          if (axles_in > rev_q) begin
            // The train came back into the section.
            rev_d   = '0;
            state_d = tom_pkg::ST_ENTERED;
          end else if (section_status == tom_pkg::SectClear) begin
            exit_d   = now_seconds;
            serial_d = serial_q + 16'd1;
            state_d  = tom_pkg::ST_COMPUTE;
          end
        end
        tom_pkg::ST_COMPUTE:     state_d = tom_pkg::ST_SAVE_AXLES;
        tom_pkg::ST_SAVE_AXLES:  state_d = tom_pkg::ST_SAVE_SERIAL;
        tom_pkg::ST_SAVE_SERIAL: state_d = tom_pkg::ST_SAVE_ENTRY;
        tom_pkg::ST_SAVE_ENTRY:  state_d = tom_pkg::ST_SAVE_EXIT;
        tom_pkg::ST_SAVE_EXIT:   state_d = tom_pkg::ST_POST;
        tom_pkg::ST_POST: begin
          res_d.record_valid  = 1'b1;
          res_d.occupied_text = tom_pkg::dur_text(dur_q[0]);
          res_d.loading_text  = tom_pkg::dur_text(dur_q[1]);
          res_d.axle_text     = tom_pkg::axle_text(cnt_q[0]);
          res_d.serial_text   = tom_pkg::serial_text(cnt_q[1]);
          res_d.entry_seconds = entry_q;
          res_d.exit_seconds  = exit_q;
          peak_d  = '0;
          rev_d   = '0;
          entry_d = '0;
          load_d  = '0;
          exit_d  = '0;
          state_d = tom_pkg::ST_WAITING;
        end
        default: state_d = tom_pkg::ST_NOT_STARTED;
      endcase
    end
    res_d.monitor_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      state_q   <= tom_pkg::ST_NOT_STARTED;
      peak_q    <= '0;
      rev_q     <= '0;
      entry_q   <= '0;
      load_q    <= '0;
      exit_q    <= '0;
      serial_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      state_q  <= state_d;
      peak_q   <= peak_d;
      rev_q    <= rev_d;
      entry_q  <= entry_d;
      load_q   <= load_d;
      exit_q   <= exit_d;
      serial_q <= serial_d;
    end
  end

  // Conversion lanes hold data only; the sequencer decides when they count.
  always_ff @(posedge clk_i) begin
    dur_q <= dur_d;
    cnt_q <= cnt_d;
  end

  // Output register with a skid register behind it. The slave side stays
  // ready as long as the skid entry is free.
  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  tom_pkg::res_t out_q, out_d;
  tom_pkg::res_t skid_q, skid_d;

  assign s_axis_tready = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (in_fire) begin
      if (!out_valid_q || m_axis_tready) begin
        out_d       = res_d;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_d;
        skid_valid_d = 1'b1;
      end
    end else if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.record_valid;
  assign m_axis_tdata  = {4'b0000, out_q.exit_seconds, out_q.entry_seconds,
                          out_q.serial_text, out_q.axle_text, out_q.loading_text,
                          out_q.occupied_text, out_q.monitor_state};

  // The skid entry only fills behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a beat while the output register is empty");

  // Every accepted tick leaves the output register holding a result beat.
  a_tick_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick produced no result beat");

  // A posted record always returns the sequencer to waiting.
  a_post_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state_q == tom_pkg::ST_POST |=> state_q == tom_pkg::ST_WAITING)
    else $error("post step did not return to waiting");

  // A record beat reports the waiting state.
  a_record_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.record_valid |-> out_q.monitor_state == tom_pkg::ST_WAITING)
    else $error("record beat carries a state other than waiting");

  // The sequencer only moves on an accepted tick.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("sequencer moved without an accepted tick");

endmodule
`default_nettype wire
